>>> hw/rtl/csc_pkg.sv
// Shared constants and elaboration-time helpers for the cubic sine/cosine unit.
// Holds the Q32 angle and polynomial constants and the rounding used to narrow them.
// No dependencies.
package csc_pkg;

	// Field widths of the item ports
	localparam int unsigned ANGLE_W       = 32;
	localparam int unsigned VALUE_W       = 18;
	localparam int unsigned FRAC_BITS_DEF = 16;

	// Width of the offset angle that enters the remainder pipeline
	localparam int unsigned U_W = 34;

	// Constants held with 32 fraction bits
	localparam logic signed [63:0] Q32_HALF_PI       = 64'sd6746518852;
	localparam logic signed [63:0] Q32_PI            = 64'sd13493037705;
	localparam logic signed [63:0] Q32_THREE_HALF_PI = 64'sd20239556557;
	localparam logic signed [63:0] Q32_TWO_PI        = 64'sd26986075409;
	localparam logic signed [63:0] Q32_A2            = -64'sd2487792937;
	localparam logic signed [63:0] Q32_A3            = 64'sd475623888;

	// Round a Q32 constant down by s bits, nearest with ties away from zero
	function automatic logic signed [63:0] q32_round(input logic signed [63:0] v,
			input int unsigned s);
		logic signed [63:0] half;
		half = 64'sd1 <<< (s - 1);
		if (v >= 0) begin
			return (v + half) >>> s;
		end else begin
			return -((-v + half) >>> s);
		end
	endfunction

	// Number of quotient bits needed so that d shifted by that count exceeds lim
	function automatic int unsigned quot_bits(input logic signed [63:0] d,
			input logic signed [63:0] lim);
		int unsigned n;
		n = 0;
		while ((d <<< n) <= lim) begin
			n++;
		end
		return n;
	endfunction

endpackage

>>> hw/rtl/cubic_sine_cosine_approx_unit.sv
// Top level of the cubic sine/cosine unit: range reduction and polynomial pipeline.
// Depends on csc_pkg for widths, Q32 constants and elaboration helpers.
//
// The unit takes an angle in radians (signed, FRAC_BITS fraction bits) and an operation
// bit (0 sine, 1 cosine) and returns sign * (1 + a2*t^2 + a3*t^3), where t is the angle
// reduced to [0, 2pi) and mirrored into its quadrant; the result has FRAC_BITS fraction
// bits, is clamped to -1..1 and is masked to the 18-bit value port. One item enters per
// clock cycle while req_stall is low. The pipeline stages are, in order: offset, quotient
// estimate by reciprocal multiplication, remainder, one correction step, quadrant,
// square, cube, coefficient products, and the final sum with rounding, sign and clamp.
// Each stage holds its item under stall and empty stages fill while the output waits,
// so req_stall rises only when every stage holds an item and the result is not being
// taken.
module cubic_sine_cosine_approx_unit #(
	parameter int unsigned FRAC_BITS = csc_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic                                operation,
	input  logic signed [csc_pkg::ANGLE_W-1:0]  angle,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic signed [csc_pkg::VALUE_W-1:0]  value
);
	import csc_pkg::*;

	// Constants narrowed to FRAC_BITS
	localparam int unsigned QS = 32 - FRAC_BITS;
	localparam logic signed [63:0] HALF_PI_C  = q32_round(Q32_HALF_PI, QS);
	localparam logic signed [63:0] PI_C       = q32_round(Q32_PI, QS);
	localparam logic signed [63:0] THREE_HP_C = q32_round(Q32_THREE_HALF_PI, QS);
	localparam logic signed [63:0] TWO_PI_C   = q32_round(Q32_TWO_PI, QS);
	localparam logic signed [63:0] A2_C       = q32_round(Q32_A2, QS);
	localparam logic signed [63:0] A3_C       = q32_round(Q32_A3, QS);

	// Offset by a multiple of 2pi that makes every angle non-negative
	localparam logic signed [63:0] OFFS_C = ((64'sd1 <<< (ANGLE_W - 1)) / TWO_PI_C + 1)
		* TWO_PI_C;
	localparam logic signed [63:0] UMAX_C = (64'sd1 <<< (ANGLE_W - 1)) - 1 + HALF_PI_C
		+ OFFS_C;
	localparam int unsigned NQ = quot_bits(TWO_PI_C, UMAX_C);

	// Reciprocal of 2pi: the estimate from the top bits of the angle is low by at most one
	localparam int unsigned UHW = U_W - FRAC_BITS;
	localparam logic signed [63:0] RECIP_C = (64'sd1 <<< U_W) / TWO_PI_C;
	localparam int unsigned RCW = $clog2(RECIP_C + 1);

	// Datapath widths
	localparam int unsigned RW  = FRAC_BITS + 3;
	localparam int unsigned TW  = FRAC_BITS + 1;
	localparam int unsigned T2W = FRAC_BITS + 2;
	localparam int unsigned T3W = FRAC_BITS + 2;
	localparam int unsigned AW  = FRAC_BITS + 1;
	localparam int unsigned PRW = AW + T2W + 1;
	localparam int unsigned PW  = PRW + 1;

	localparam logic [U_W-1:0] ADD_SIN = OFFS_C[U_W-1:0];
	localparam logic signed [63:0] OFFS_COS_C = OFFS_C + HALF_PI_C;
	localparam logic [U_W-1:0] ADD_COS = OFFS_COS_C[U_W-1:0];
	localparam logic [RCW-1:0] RECIP_R = RECIP_C[RCW-1:0];
	localparam logic [RW-1:0] HALF_R  = HALF_PI_C[RW-1:0];
	localparam logic [RW-1:0] PI_R    = PI_C[RW-1:0];
	localparam logic [RW-1:0] THREE_R = THREE_HP_C[RW-1:0];
	localparam logic [RW-1:0] TWO_PI_R = TWO_PI_C[RW-1:0];
	localparam logic [RW:0]   TWO_PI_X = TWO_PI_C[RW:0];
	localparam logic signed [AW-1:0] A2_S = A2_C[AW-1:0];
	localparam logic signed [AW-1:0] A3_S = A3_C[AW-1:0];
	localparam logic [2*TW:0] RND_SQ = (2*TW+1)'(1) << (FRAC_BITS - 1);
	localparam logic [T2W+TW:0] RND_CU = (T2W+TW+1)'(1) << (FRAC_BITS - 1);
	localparam logic signed [PW-1:0] RND_P = PW'(1) << (FRAC_BITS - 1);
	localparam logic signed [PW-1:0] RND_N = RND_P - 1;
	localparam logic signed [PW-1:0] ONE_SH = PW'(1) << (2 * FRAC_BITS);
	localparam logic signed [PW-1:0] ONE_P = PW'(1) << FRAC_BITS;
	localparam logic signed [PW-1:0] NEG_ONE_P = -ONE_P;

	// Pipeline registers
	logic              vld_s1;
	logic [U_W-1:0]    u_s1;
	logic              vld_s2;
	logic [U_W-1:0]    u_s2;
	logic [NQ-1:0]     q_s2;
	logic              vld_s3;
	logic [RW:0]       r_s3;
	logic              vld_s4;
	logic [RW-1:0]     rr_s4;
	logic              vld_s5, neg_s5;
	logic [TW-1:0]     t_s5;
	logic              vld_s6, neg_s6;
	logic [TW-1:0]     t_s6;
	logic [T2W-1:0]    t2_s6;
	logic              vld_s7, neg_s7;
	logic [T2W-1:0]    t2_s7;
	logic [T3W-1:0]    t3_s7;
	logic              vld_s8, neg_s8;
	logic signed [PRW-1:0] pa_s8, pb_s8;
	logic              vld_s9;
	logic signed [VALUE_W-1:0] value_s9;

	// Per-stage ready: a stage loads when empty or when its successor moves
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7, rdy_s8, rdy_s9;

	assign rdy_s9 = !vld_s9 || !rsp_stall;
	assign rdy_s8 = !vld_s8 || rdy_s9;
	assign rdy_s7 = !vld_s7 || rdy_s8;
	assign rdy_s6 = !vld_s6 || rdy_s7;
	assign rdy_s5 = !vld_s5 || rdy_s6;
	assign rdy_s4 = !vld_s4 || rdy_s5;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;

	assign req_stall = !rdy_s1;
	assign rsp_valid = vld_s9;
	assign value     = value_s9;

	// Stage 1: add the cosine shift and the 2pi multiple that makes the angle positive
	logic [U_W-1:0] u_next;
	assign u_next = {{(U_W - ANGLE_W){angle[ANGLE_W-1]}}, angle}
		+ (operation ? ADD_COS : ADD_SIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && req_valid) begin
			u_s1 <= u_next;
		end
	end

	// Stage 2: estimate the quotient by 2pi from the integer part times the reciprocal
	logic [UHW+RCW-1:0] q_prod;
	assign q_prod = {{RCW{1'b0}}, u_s1[U_W-1:FRAC_BITS]} * {{UHW{1'b0}}, RECIP_R};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (rdy_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			u_s2 <= u_s1;
			q_s2 <= q_prod[UHW +: NQ];
		end
	end

	// Stage 3: remove the estimated turns, leaving a remainder below twice 2pi
	logic [NQ+RW-1:0] qd;
	logic [U_W-1:0]   r_diff;
	assign qd     = {{RW{1'b0}}, q_s2} * {{NQ{1'b0}}, TWO_PI_R};
	assign r_diff = u_s2 - U_W'(qd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (rdy_s3) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && vld_s2) begin
			r_s3 <= r_diff[RW:0];
		end
	end

	// Stage 4: drop one more 2pi when the estimate was one short
	logic [RW:0] r_sub;
	assign r_sub = r_s3 - TWO_PI_X;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (rdy_s4) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && vld_s3) begin
			rr_s4 <= (r_s3 >= TWO_PI_X) ? r_sub[RW-1:0] : r_s3[RW-1:0];
		end
	end

	// Stage 5: pick the quadrant, the mirrored argument and the sign
	logic [RW-1:0] t_diff;
	logic          neg_next;

	always_comb begin
		if (rr_s4 < HALF_R) begin
			t_diff   = HALF_R - rr_s4;
			neg_next = 1'b0;
		end else if (rr_s4 < PI_R) begin
			t_diff   = rr_s4 - HALF_R;
			neg_next = 1'b0;
		end else if (rr_s4 < THREE_R) begin
			t_diff   = THREE_R - rr_s4;
			neg_next = 1'b1;
		end else begin
			t_diff   = rr_s4 - THREE_R;
			neg_next = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (rdy_s5) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && vld_s4) begin
			t_s5   <= t_diff[TW-1:0];
			neg_s5 <= neg_next;
		end
	end

	// Stage 6: square the argument and round
	logic [2*TW-1:0] sq;
	logic [2*TW:0]   sq_rnd;
	assign sq     = {{TW{1'b0}}, t_s5} * {{TW{1'b0}}, t_s5};
	assign sq_rnd = {1'b0, sq} + RND_SQ;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (rdy_s6) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s6 && vld_s5) begin
			t_s6   <= t_s5;
			t2_s6  <= sq_rnd[FRAC_BITS +: T2W];
			neg_s6 <= neg_s5;
		end
	end

	// Stage 7: cube from the rounded square and round
	logic [T2W+TW-1:0] cu;
	logic [T2W+TW:0]   cu_rnd;
	assign cu     = {{TW{1'b0}}, t2_s6} * {{T2W{1'b0}}, t_s6};
	assign cu_rnd = {1'b0, cu} + RND_CU;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (rdy_s7) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s7 && vld_s6) begin
			t2_s7  <= t2_s6;
			t3_s7  <= cu_rnd[FRAC_BITS +: T3W];
			neg_s7 <= neg_s6;
		end
	end

	// Stage 8: coefficient products
	logic signed [PRW-1:0] pa_next, pb_next;
	assign pa_next = A2_S * $signed({1'b0, t2_s7});
	assign pb_next = A3_S * $signed({1'b0, t3_s7});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (rdy_s8) begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s8 && vld_s7) begin
			pa_s8  <= pa_next;
			pb_s8  <= pb_next;
			neg_s8 <= neg_s7;
		end
	end

	// Stage 9: add one and round away from zero in one sum, clamp, then apply the sign.
	// A negative sum takes one less than half as bias, so the floor shift rounds its
	// magnitude away from zero.
	logic signed [PW-1:0] psum, hsh, hill, hill_clp, hill_sgn;

	always_comb begin
		psum = PW'(pa_s8) + PW'(pb_s8);
		hsh  = psum + ONE_SH + (psum[PW-1] ? RND_N : RND_P);
		hill = hsh >>> FRAC_BITS;
		if (hill > ONE_P) begin
			hill_clp = ONE_P;
		end else if (hill < NEG_ONE_P) begin
			hill_clp = NEG_ONE_P;
		end else begin
			hill_clp = hill;
		end
		hill_sgn = neg_s8 ? -hill_clp : hill_clp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (rdy_s9) begin
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s9 && vld_s8) begin
			value_s9 <= hill_sgn[VALUE_W-1:0];
		end
	end

	// Checks
	localparam bit RANGE_CHK = (FRAC_BITS <= VALUE_W - 2);

	// Back-pressure reaches the input only from a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (rsp_valid && rsp_stall))
		else $error("input stalled without a stalled result");

	// The corrected remainder ends below 2pi
	a_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> (rr_s4 < TWO_PI_R))
		else $error("reduced angle not below two pi");

	// A delivered value lies within -1..1
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (!RANGE_CHK || ((int'(value) <= (1 << FRAC_BITS))
		&& (int'(value) >= -(1 << FRAC_BITS)))))
		else $error("result outside -1..1");

endmodule

>>> test/cubic_sine_cosine_approx_unit_tb.sv
// Self-checking testbench for the cubic sine/cosine unit: directed and random angles.
// Predicts each value in fixed point and compares it with the unit's result stream.
// Depends on the cubic_sine_cosine_approx_unit RTL and csc_pkg.
module cubic_sine_cosine_approx_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned FRAC        = 16;
	localparam int unsigned VW          = csc_pkg::VALUE_W;
	localparam int          HOLD_CYCLES = 400;
	localparam int          CYCLE_LIMIT = 300000;
	localparam int          DRAIN_WAIT  = 60;

	// Operation codes on the operation port
	localparam logic OP_SINE   = 1'b0;
	localparam logic OP_COSINE = 1'b1;

	// Angle and polynomial constants with 32 fraction bits
	localparam longint HALF_PI_Q32       = 64'sd6746518852;
	localparam longint PI_Q32            = 64'sd13493037705;
	localparam longint THREE_HALF_PI_Q32 = 64'sd20239556557;
	localparam longint TWO_PI_Q32        = 64'sd26986075409;
	localparam longint A2_Q32            = -64'sd2487792937;
	localparam longint A3_Q32            = 64'sd475623888;

	typedef struct {
		logic                              op;
		logic signed [csc_pkg::ANGLE_W-1:0] ang;
	} angle_item_t;

	typedef struct {
		logic                              op;
		logic signed [csc_pkg::ANGLE_W-1:0] ang;
		logic [VW-1:0]                     value;
	} value_entry_t;

	logic                               clk       = 1'b0;
	logic                               arst_n    = 1'b0;
	logic                               req_valid = 1'b0;
	logic                               req_stall;
	logic                               operation = 1'b0;
	logic signed [csc_pkg::ANGLE_W-1:0] angle     = '0;
	logic                               rsp_valid;
	logic                               rsp_stall = 1'b1;
	logic signed [VW-1:0]               value;

	angle_item_t  pending_angles[$];
	value_entry_t expected_values[$];

	logic req_fire_q = 1'b0;
	logic rsp_fire_q = 1'b0;
	int   max_gap    = 16;
	int   max_stall  = 16;
	int   hold_ask   = 0;
	int   n_errors   = 0;
	int   n_checked  = 0;
	int   n_sent     = 0;
	int   n_cosine   = 0;
	int   n_held     = 0;
	int   cycles     = 0;

	cubic_sine_cosine_approx_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.operation (operation),
		.angle     (angle),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.value     (value)
	);

	always #5 clk = ~clk;

	// Round away s bits, nearest with ties away from zero
	function automatic longint round_frac(input longint v, input int unsigned s);
		longint half;
		half = longint'(1) <<< (s - 1);
		if (v >= 0) begin
			return (v + half) >>> s;
		end
		return -((-v + half) >>> s);
	endfunction

	// Evaluate 1 + a2*t^2 + a3*t^3 at the mirrored argument
	function automatic longint cubic_hill(input longint t);
		longint t2, t3, a2, a3;
		t2 = round_frac(t * t, FRAC);
		t3 = round_frac(t2 * t, FRAC);
		a2 = round_frac(A2_Q32, 32 - FRAC);
		a3 = round_frac(A3_Q32, 32 - FRAC);
		return (longint'(1) <<< FRAC) + round_frac(a2 * t2 + a3 * t3, FRAC);
	endfunction

	// Reduce the angle, pick the quadrant and return the clamped, masked value
	function automatic logic [VW-1:0] sine_cosine_value(input logic op,
			input logic signed [csc_pkg::ANGLE_W-1:0] ang);
		longint one, hp, pi_f, thp, tp, x, h;
		one  = longint'(1) <<< FRAC;
		hp   = round_frac(HALF_PI_Q32, 32 - FRAC);
		pi_f = round_frac(PI_Q32, 32 - FRAC);
		thp  = round_frac(THREE_HALF_PI_Q32, 32 - FRAC);
		tp   = round_frac(TWO_PI_Q32, 32 - FRAC);
		x = longint'(ang);
		if (op == OP_COSINE) begin
			x = x + hp;
		end
		x = x % tp;
		if (x < 0) begin
			x = x + tp;
		end
		if (x < hp) begin
			h = cubic_hill(hp - x);
		end else if (x < pi_f) begin
			h = cubic_hill(x - hp);
		end else if (x < thp) begin
			h = -cubic_hill(thp - x);
		end else begin
			h = -cubic_hill(x - thp);
		end
		if (h > one) begin
			h = one;
		end
		if (h < -one) begin
			h = -one;
		end
		return h[VW-1:0];
	endfunction

	// Queue one angle for the driver
	task automatic queue_angle(input logic op, input longint a);
		angle_item_t it;
		it.op  = op;
		it.ang = a[csc_pkg::ANGLE_W-1:0];
		pending_angles.push_back(it);
	endtask

	// Queue random angles: full range, within one turn of zero, quadrant edges and range ends
	task automatic queue_random_angles(input int count);
		longint hp, a;
		int     k;
		logic   op;
		hp = round_frac(HALF_PI_Q32, 32 - FRAC);
		for (int i = 0; i < count; i++) begin
			op = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 3))
				0: begin
					a = longint'($signed($urandom()));
				end
				1: begin
					a = longint'($urandom_range(0, 823548)) - 411774;
				end
				2: begin
					k = int'($urandom_range(0, 40)) - 20;
					a = longint'(k) * hp + longint'($urandom_range(0, 8)) - 4;
				end
				default: begin
					a = longint'($urandom_range(0, 1023));
					if ($urandom_range(0, 1)) begin
						a = 64'sd2147483647 - a;
					end else begin
						a = -64'sd2147483648 + a;
					end
				end
			endcase
			queue_angle(op, a);
		end
	endtask

	// Offer items, waiting a drawn number of cycles after each accepted one
	always @(negedge clk) begin : drive_angles
		static int   gap_left = 0;
		angle_item_t it;
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_fire_q) begin
			if (req_fire_q) begin
				gap_left = int'($urandom_range(0, max_gap));
			end
			if (gap_left > 0) begin
				gap_left--;
				req_valid <= 1'b0;
			end else if (pending_angles.size() > 0) begin
				it = pending_angles.pop_front();
				req_valid <= 1'b1;
				operation <= it.op;
				angle     <= it.ang;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Stall results per item, plus one long hold-off on request
	always @(negedge clk) begin : drive_stall
		static int stall_left = 0;
		static int hold_left  = 0;
		static int hold_seen  = 0;
		if (!arst_n) begin
			rsp_stall <= 1'b1;
		end else begin
			if (rsp_fire_q) begin
				stall_left = int'($urandom_range(0, max_stall));
			end
			if (hold_seen != hold_ask) begin
				hold_seen = hold_ask;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// Predict accepted items and check results against the oldest prediction
	always @(posedge clk) begin : check_values
		value_entry_t e;
		if (!arst_n) begin
			req_fire_q <= 1'b0;
			rsp_fire_q <= 1'b0;
		end else begin
			req_fire_q <= req_valid && !req_stall;
			rsp_fire_q <= rsp_valid && !rsp_stall;
			if (req_valid && req_stall) begin
				n_held++;
			end
			if (req_valid && !req_stall) begin
				e.op    = operation;
				e.ang   = angle;
				e.value = sine_cosine_value(operation, angle);
				expected_values.push_back(e);
				n_sent++;
				if (operation == OP_COSINE) begin
					n_cosine++;
				end
			end
			if (rsp_valid && !rsp_stall) begin
				if (expected_values.size() == 0) begin
					n_errors++;
					$display("%0t: unexpected result value=%h", $time, value);
				end else begin
					e = expected_values.pop_front();
					n_checked++;
					if (value !== e.value) begin
						n_errors++;
						$display("%0t: op=%0d angle=%h expected value=%h actual=%h",
							$time, e.op, e.ang, e.value, value);
					end
				end
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin : watchdog
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still expected", $time,
				expected_values.size());
			$display("** cubic_sine_cosine_approx_unit: FAILED **");
			$finish;
		end
	end

	// Reset, then run directed and random phases
	initial begin : run_phases
		longint hp, pi_f, thp, tp;
		longint corner[12];
		hp   = round_frac(HALF_PI_Q32, 32 - FRAC);
		pi_f = round_frac(PI_Q32, 32 - FRAC);
		thp  = round_frac(THREE_HALF_PI_Q32, 32 - FRAC);
		tp   = round_frac(TWO_PI_Q32, 32 - FRAC);
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Directed: zero, quadrant edges, one turn, and the ends of the angle range
		corner = '{0, 1, -1, hp - 1, hp, pi_f, thp, tp - 1, tp, -tp,
			64'sd2147483647, -64'sd2147483648};
		foreach (corner[i]) begin
			queue_angle(OP_SINE, corner[i]);
			queue_angle(OP_COSINE, corner[i]);
		end
		wait (pending_angles.size() == 0);

		// Random with gaps on both sides
		queue_random_angles(300);
		wait (pending_angles.size() == 0);

		// Back-to-back input against a long output hold-off
		max_gap   = 0;
		max_stall = 0;
		queue_random_angles(200);
		hold_ask++;
		wait (pending_angles.size() == 0);

		// Full input rate against a stalling receiver
		max_stall = 16;
		queue_random_angles(300);
		wait (pending_angles.size() == 0);

		// Sparse input against a free-running receiver
		max_gap   = 16;
		max_stall = 0;
		queue_random_angles(400);
		wait (pending_angles.size() == 0 && !req_valid && expected_values.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Sent %0d angles (%0d cosine), checked %0d values.", n_sent, n_cosine,
			n_checked);
		$display("Input was held off for %0d cycles; %0d mismatches.", n_held, n_errors);
		if (n_errors == 0 && expected_values.size() == 0) begin
			$display("** cubic_sine_cosine_approx_unit: PASSED **");
		end else begin
			$display("** cubic_sine_cosine_approx_unit: FAILED **");
		end
		$finish;
	end

endmodule
